[hdl/imh_pkg.sv]
package imh_pkg;

   localparam int KEY_W = 32;
   localparam int ID_W  = 10;

   typedef enum logic [1:0] {
      CMD_LOAD     = 2'd0,
      CMD_EXTRACT  = 2'd1,
      CMD_DECREASE = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_RSVD     = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]              command;
      logic signed [KEY_W-1:0] key;
      logic [ID_W-1:0]         item_id;
      logic                    last;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]         min_id;
      logic signed [KEY_W-1:0] min_key;
      logic [1:0]              status;
   } rsp_type;

endpackage

[hdl/imh_ram.sv]
module imh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/imh_fifo.sv]
module imh_fifo import imh_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output req_type out_data
);

   // two-entry queue between front and back
   req_type    buf_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = buf_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) buf_ff[wp_ff] <= in_data;
   end

endmodule

[hdl/imh_core.sv]
module imh_core import imh_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  req_type cmd_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int PW = AW + 1;
   localparam logic [PW-1:0] CAP = PW'(CAPACITY);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_RD    = 10'b0000000010,
      S_CMP   = 10'b0000000100,
      S_POS   = 10'b0000001000,
      S_DEC   = 10'b0000010000,
      S_EXT   = 10'b0000100000,
      S_EXT2  = 10'b0001000000,
      S_BUILD = 10'b0010000000,
      S_SWAP  = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff;

   // heap positions are 1-based; key and id memories are addressed by position-1
   logic [PW-1:0] size_ff, loaded_ff, p_ff, bi_ff, q_ff;
   logic          up_ff, build_ff;
   logic [1:0]    ph_ff;
   logic signed [KEY_W-1:0] kp_ff, kl_ff, kr_ff;
   logic [ID_W-1:0]         ip_ff, il_ff, ir_ff;
   rsp_type       out_ff;
   logic          out_v_ff;

   // memory ports
   logic            k_we, i_we, m_we;
   logic [AW-1:0]   k_wa, i_wa, m_wa, k_ra, i_ra, m_ra;
   logic [KEY_W-1:0] k_wd, k_rd;
   logic [ID_W-1:0] i_wd, i_rd;
   logic [PW-1:0]   m_wd, m_rd;

   imh_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_keys (
      .clock(clock), .wr_en(k_we), .wr_addr(k_wa), .wr_data(k_wd),
      .rd_addr(k_ra), .rd_data(k_rd));
   imh_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_ids (
      .clock(clock), .wr_en(i_we), .wr_addr(i_wa), .wr_data(i_wd),
      .rd_addr(i_ra), .rd_data(i_rd));
   imh_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_pos (
      .clock(clock), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
      .rd_addr(m_ra), .rd_data(m_rd));

   function automatic logic [AW-1:0] adr(input logic [PW-1:0] p);
      logic [PW-1:0] t;
      t = p - PW'(1);
      return t[AW-1:0];
   endfunction

   logic [PW-1:0] lc, rc, par, best;
   logic          go_l, go_r, up_sw;
   logic signed [KEY_W-1:0] kb;
   logic [ID_W-1:0]         ib;
   logic [ID_W-1:0]         ld_id;

   assign lc  = {p_ff[PW-2:0], 1'b0};
   assign rc  = {p_ff[PW-2:0], 1'b1};
   assign par = {1'b0, p_ff[PW-1:1]};
   assign ld_id = ID_W'(loaded_ff);

   // sift-down choice: left wins ties against right
   always_comb begin
      go_l = (lc <= size_ff) && (p_ff[PW-1] == 1'b0) && (kl_ff < kp_ff);
      kb = go_l ? kl_ff : kp_ff;
      go_r = (rc <= size_ff) && (p_ff[PW-1] == 1'b0) && (kr_ff < kb);
      best = go_r ? rc : (go_l ? lc : p_ff);
      kb   = go_r ? kr_ff : kb;
      ib   = go_r ? ir_ff : il_ff;
      up_sw = (p_ff > PW'(1)) && (kl_ff > kp_ff);
   end

   assign cmd_ready = (state_ff == S_IDLE) && !out_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      k_we = 1'b0; i_we = 1'b0; m_we = 1'b0;
      k_wa = adr(p_ff); i_wa = adr(p_ff); m_wa = '0;
      k_wd = kp_ff; i_wd = ip_ff; m_wd = p_ff;
      k_ra = adr(p_ff); i_ra = adr(p_ff); m_ra = AW'(cmd_data.item_id);
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               unique case (cmd_data.command)
                  CMD_LOAD: begin
                     if (loaded_ff < CAP && size_ff < CAP) begin
                        k_we = 1'b1; i_we = 1'b1; m_we = 1'b1;
                        k_wa = adr(size_ff + PW'(1));
                        i_wa = k_wa;
                        k_wd = cmd_data.key;
                        i_wd = ld_id;
                        m_wa = loaded_ff[AW-1:0];
                        m_wd = size_ff + PW'(1);
                     end
                  end
                  CMD_EXTRACT: begin
                     k_ra = adr(PW'(1)); i_ra = adr(PW'(1));
                  end
                  CMD_DECREASE: m_ra = AW'(cmd_data.item_id);
                  default: ;
               endcase
            end
         end
         // phased reads of p (ph 0), then left/parent (1), then right (2)
         S_RD: begin
            unique case (ph_ff)
               2'd0: begin k_ra = adr(p_ff); i_ra = adr(p_ff); end
               2'd1: begin
                  k_ra = up_ff ? adr(par) : adr(lc);
                  i_ra = k_ra;
               end
               default: begin k_ra = adr(rc); i_ra = adr(rc); end
            endcase
         end
         S_SWAP: begin
            // write slot q (child on sift-down, parent on sift-up) with the entry
            // from p; the entry from q goes to p in the S_CMP path below
            k_we = 1'b1; i_we = 1'b1; m_we = 1'b1;
            k_wa = adr(q_ff); i_wa = adr(q_ff);
            k_wd = kp_ff; i_wd = ip_ff;
            m_wa = AW'(ip_ff); m_wd = q_ff;
         end
         S_CMP: begin
            if (up_ff ? up_sw : (best != p_ff)) begin
               k_we = 1'b1; i_we = 1'b1; m_we = 1'b1;
               k_wa = adr(p_ff); i_wa = adr(p_ff);
               k_wd = up_ff ? kl_ff : kb;
               i_wd = up_ff ? il_ff : ib;
               m_wa = AW'(i_wd); m_wd = p_ff;
            end
         end
         S_POS: ;
         S_DEC: begin
            k_we = 1'b1; k_wa = adr(p_ff); k_wd = kp_ff;
         end
         S_EXT: begin
            k_ra = adr(size_ff); i_ra = adr(size_ff);
         end
         S_EXT2: begin
            k_we = 1'b1; i_we = 1'b1; m_we = 1'b1;
            k_wa = adr(PW'(1)); i_wa = k_wa;
            k_wd = k_rd; i_wd = i_rd;
            m_wa = AW'(i_rd); m_wd = PW'(1);
         end
         S_BUILD: ;
         S_OUT: begin
            m_we = 1'b1; m_wa = AW'(out_ff.min_id); m_wd = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         size_ff   <= '0;
         loaded_ff <= '0;
         out_v_ff  <= 1'b0;
         build_ff  <= 1'b0;
      end else begin
         if (out_v_ff && rsp_ready) out_v_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid && cmd_ready) begin
                  unique case (cmd_data.command)
                     CMD_LOAD: begin
                        if (loaded_ff < CAP && size_ff < CAP) begin
                           size_ff   <= size_ff + PW'(1);
                           loaded_ff <= loaded_ff + PW'(1);
                        end else begin
                           out_ff   <= '{min_id: '0, min_key: '0, status: ST_OVERFLOW};
                           out_v_ff <= 1'b1;
                        end
                        if (cmd_data.last) begin
                           bi_ff    <= (loaded_ff < CAP && size_ff < CAP) ?
                                       (size_ff + PW'(1)) >> 1 : size_ff >> 1;
                           state_ff <= S_BUILD;
                        end
                     end
                     CMD_EXTRACT: begin
                        if (size_ff == '0) begin
                           out_ff   <= '{min_id: '0, min_key: '0, status: ST_EMPTY};
                           out_v_ff <= 1'b1;
                        end else begin
                           state_ff <= S_EXT;
                        end
                     end
                     CMD_DECREASE: begin
                        kp_ff <= cmd_data.key;
                        if (PW'(cmd_data.item_id) < loaded_ff &&
                            {{(32-ID_W){1'b0}}, cmd_data.item_id} < 32'(CAPACITY))
                           state_ff <= S_POS;
                     end
                     default: ;
                  endcase
               end
            end
            S_POS: begin
               if (m_rd != '0 && m_rd <= size_ff) begin
                  p_ff <= m_rd; state_ff <= S_DEC;
               end else state_ff <= S_IDLE;
            end
            S_DEC: begin
               up_ff <= 1'b1; ph_ff <= 2'd0; build_ff <= 1'b0;
               state_ff <= S_RD;
            end
            S_EXT: begin
               out_ff <= '{min_id: i_rd, min_key: k_rd, status: ST_OK};
               state_ff <= S_EXT2;
            end
            S_EXT2: begin
               size_ff <= size_ff - PW'(1);
               state_ff <= S_OUT;
            end
            S_OUT: begin
               // root entry's position cleared, then sift from root
               out_v_ff <= 1'b1;
               p_ff <= PW'(1); up_ff <= 1'b0; ph_ff <= 2'd0;
               build_ff <= 1'b0;
               state_ff <= S_RD;
            end
            S_BUILD: begin
               if (bi_ff == '0) state_ff <= S_IDLE;
               else begin
                  p_ff <= bi_ff; bi_ff <= bi_ff - PW'(1);
                  up_ff <= 1'b0; ph_ff <= 2'd0; build_ff <= 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               unique case (ph_ff)
                  2'd0: ph_ff <= 2'd1;
                  2'd1: begin
                     kp_ff <= k_rd; ip_ff <= i_rd;
                     if (up_ff) begin ph_ff <= 2'd3; end
                     else ph_ff <= 2'd2;
                  end
                  2'd2: begin
                     kl_ff <= k_rd; il_ff <= i_rd; ph_ff <= 2'd3;
                  end
                  default: begin
                     if (up_ff) begin kl_ff <= k_rd; il_ff <= i_rd; end
                     else begin kr_ff <= k_rd; ir_ff <= i_rd; end
                     state_ff <= S_CMP;
                  end
               endcase
            end
            S_CMP: begin
               if (up_ff ? up_sw : (best != p_ff)) begin
                  q_ff <= up_ff ? par : best;
                  state_ff <= S_SWAP;
               end else begin
                  state_ff <= build_ff ? S_BUILD : S_IDLE;
               end
            end
            S_SWAP: begin
               p_ff <= q_ff; ph_ff <= 2'd0;
               state_ff <= S_RD;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[hdl/indexed_min_heap_top.sv]
// indexed binary min-heap with a position map
// req channel: valid/ready beat carries command, key, item_id, last
//   load appends a key (id = load order); last starts a bottom-up build
//   extract returns root id and key on rsp, then sifts down
//   decrease overwrites an item's key and sifts it up
// rsp channel: valid/ready beat carries min_id, min_key, status
//   extract always answers; overflowing loads answer with status 2
// a two-beat queue sits between the request port and the heap engine
// a load that is not last leaves the engine idle; an extract response is
//   raised in S_OUT, after the S_EXT and S_EXT2 steps, before the sift-down
// a sift-down level does three registered memory reads (p, left, right),
//   a compare and, if needed, a swap; a sift-up level reads p and its parent
//   before its compare and swap; a build runs one sift-down per internal node
// the engine takes no new command while a response is still pending
// reset clears the counts; heap memories are left as they are
module indexed_min_heap_top import imh_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    q_valid, q_ready;
   req_type q_data;

   // front queue
   imh_fifo u_fifo (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_data(req_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data));

   // heap engine
   imh_core #(.CAPACITY(CAPACITY)) u_core (
      .clock(clock), .reset(reset),
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_data(q_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data));

endmodule
